[rtl/tcts_pkg.sv]
// ----------------------------------------------------------------------------
// tcts_pkg: shared types and constants of the tick counter task scheduler
// Field widths, operation and error codes, slot entry layout, alu bundles.
// ----------------------------------------------------------------------------
package tcts_pkg;

  localparam int KIND_W  = 3;
  localparam int IDX_W   = 4;
  localparam int INIT_W  = 15;
  localparam int PRIO_W  = 8;
  localparam int ERR_W   = 2;
  localparam int TICKS_W = 16;

  // operation codes of an input item
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK      = 3'd0,
    KIND_PICK      = 3'd1,
    KIND_LOAD_MAIN = 3'd2,
    KIND_ENQUEUE   = 3'd3,
    KIND_SET_RUN   = 3'd4,
    KIND_SET_CUR   = 3'd5
  } kind_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK        = 2'd0,
    ERR_FULL      = 2'd1,
    ERR_NOT_VALID = 2'd2
  } err_e;

  // one slot entry as held in the slot ram
  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [TICKS_W-1:0] ticks;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  typedef enum logic [1:0] {
    ALU_CMP    = 2'd0,
    ALU_DEC    = 2'd1,
    ALU_REFILL = 2'd2
  } alu_op_e;

  typedef struct packed {
    alu_op_e            op;
    logic [TICKS_W-1:0] a;
    logic [TICKS_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [TICKS_W-1:0] value;
    logic               flag;
  } alu_rsp_t;

  typedef struct packed {
    logic [IDX_W-1:0] result_index;
    logic             reschedule;
    logic             refilled;
    err_e             error;
  } result_t;

endpackage

[rtl/tcts_if.sv]
// ----------------------------------------------------------------------------
// tcts_if: valid/ready channels of the tick counter task scheduler
// Request channel carries one operation, response channel one result item.
// ----------------------------------------------------------------------------
interface tcts_in_if;
  logic                          valid;
  logic                          ready;
  logic [tcts_pkg::KIND_W-1:0]   kind;
  logic [tcts_pkg::IDX_W-1:0]    task_index;
  logic                          running;
  logic [tcts_pkg::INIT_W-1:0]   initial_ticks;
  logic [tcts_pkg::PRIO_W-1:0]   priority_req;
  logic                          preempt_held;

  modport source (
    output valid, kind, task_index, running, initial_ticks, priority_req, preempt_held,
    input  ready
  );
  modport sink (
    input  valid, kind, task_index, running, initial_ticks, priority_req, preempt_held,
    output ready
  );
endinterface

interface tcts_out_if;
  logic                        valid;
  logic                        ready;
  logic [tcts_pkg::IDX_W-1:0]  result_index;
  logic                        reschedule;
  logic                        refilled;
  logic [tcts_pkg::ERR_W-1:0]  error;

  modport source (
    output valid, result_index, reschedule, refilled, error,
    input  ready
  );
  modport sink (
    input  valid, result_index, reschedule, refilled, error,
    output ready
  );
endinterface

[rtl/tcts_ram.sv]
// ----------------------------------------------------------------------------
// tcts_ram: generic single write, single read ram
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

[rtl/tcts_alu.sv]
// ----------------------------------------------------------------------------
// tcts_alu: shared budget arithmetic unit
// Signed compare, saturating decrement and half-plus-priority refill.
// ----------------------------------------------------------------------------
module tcts_alu (
  input  tcts_pkg::alu_req_t req_i,
  output tcts_pkg::alu_rsp_t rsp_o
);

  localparam logic [tcts_pkg::TICKS_W-1:0] TICKS_MIN = {1'b1, {(tcts_pkg::TICKS_W-1){1'b0}}};
  localparam logic [tcts_pkg::TICKS_W-1:0] TICKS_MAX = {1'b0, {(tcts_pkg::TICKS_W-1){1'b1}}};

  logic [tcts_pkg::TICKS_W:0]   sum;
  logic [tcts_pkg::TICKS_W-1:0] dec;

  always_comb begin
    // floor(a / 2) sign extended, plus the unsigned priority
    sum = {req_i.a[tcts_pkg::TICKS_W-1], req_i.a[tcts_pkg::TICKS_W-1],
           req_i.a[tcts_pkg::TICKS_W-1:1]}
        + {{(tcts_pkg::TICKS_W+1-tcts_pkg::PRIO_W){1'b0}},
           req_i.b[tcts_pkg::PRIO_W-1:0]};
    dec = (req_i.a == TICKS_MIN) ? req_i.a : req_i.a - 1'b1;
    rsp_o = '0;
    unique case (req_i.op)
      tcts_pkg::ALU_CMP: begin
        rsp_o.value = req_i.a;
        rsp_o.flag  = $signed(req_i.a) > $signed(req_i.b);
      end
      tcts_pkg::ALU_DEC: begin
        rsp_o.value = dec;
        rsp_o.flag  = dec[tcts_pkg::TICKS_W-1] || (dec == '0);
      end
      tcts_pkg::ALU_REFILL: begin
        // only the upper limit is checked here
        if (!sum[tcts_pkg::TICKS_W] && sum[tcts_pkg::TICKS_W-1]) begin
          rsp_o.value = TICKS_MAX;
        end else begin
          rsp_o.value = sum[tcts_pkg::TICKS_W-1:0];
        end
      end
      default: begin
        rsp_o = '0;
      end
    endcase
  end

endmodule

[rtl/tick_counter_task_scheduler_core.sv]
// ----------------------------------------------------------------------------
// tick_counter_task_scheduler_core: tick counting task scheduler
// Slot table with tick budgets and priorities, tick charging and best pick.
// ----------------------------------------------------------------------------
//
//  channel  dir  port   handshake      payload
//  -------  ---  -----  -------------  ---------------------------------------
//  request  in   req_i  valid / ready  kind, task_index, running,
//                                      initial_ticks, priority_req, preempt_held
//  result   out  rsp_o  valid / ready  result_index, reschedule, refilled, error
//
//  steps: load, enqueue, set running, set current and unused kinds act at
//  once and then hold; a tick does a slot ram read, decrement and write
//  back, hold; a pick scans all slots and, when the best budget is zero,
//  refills them and scans again, one slot ram read per cycle via the shared alu.
//  reset clears valid and running marks and current slot and sets the free
//  slot pointer to slot 1 at once; budgets and priorities live in ram and need no clearing pass.
//  a finished result waits in the output register; the request side is
//  ready again right after it is moved there, and stalls while it is full.
//
module tick_counter_task_scheduler_core #(
  parameter int TASK_SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tcts_in_if.sink           req_i,
  tcts_out_if.source        rsp_o
);

  localparam int SLOT_W = $clog2(TASK_SLOTS);
  localparam int NF_W   = $clog2(TASK_SLOTS + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);
  localparam logic [NF_W-1:0]   NF_FULL   = NF_W'(TASK_SLOTS);

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_TICK   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_REFILL = 5'b01000,
    ST_HOLD   = 5'b10000
  } state_e;

  state_e                  state_q, state_d;
  logic [TASK_SLOTS-1:0]   valid_q, valid_d;
  logic [TASK_SLOTS-1:0]   running_q, running_d;
  logic [tcts_pkg::IDX_W-1:0] current_q, current_d;
  logic [NF_W-1:0]         nf_q, nf_d;
  logic [SLOT_W-1:0]       issue_q, issue_d;
  logic                    issue_done_q, issue_done_d;
  logic                    live_q, live_d;
  logic                    pass_q, pass_d;
  logic                    out_valid_q, out_valid_d;

  logic [SLOT_W-1:0]       data_idx_q, data_idx_d;
  logic [tcts_pkg::TICKS_W-1:0] best_q, best_d;
  logic [SLOT_W-1:0]       sel_q, sel_d;
  logic                    held_q, held_d;
  tcts_pkg::result_t       res_q, res_d;
  tcts_pkg::result_t       out_q, out_d;

  // slot ram ports
  logic                    ram_wr_en;
  logic [SLOT_W-1:0]       ram_wr_addr;
  tcts_pkg::slot_entry_t   ram_wr_data;
  logic                    ram_rd_en;
  logic [SLOT_W-1:0]       ram_rd_addr;
  logic [tcts_pkg::ENTRY_W-1:0] ram_rd_data;
  tcts_pkg::slot_entry_t   rd_entry;

  tcts_pkg::alu_req_t      alu_req;
  tcts_pkg::alu_rsp_t      alu_rsp;

  logic                    in_acc;
  logic [SLOT_W-1:0]       cur_idx;
  logic                    cur_ok;
  logic                    data_ok;

  tcts_ram #(
    .WIDTH (tcts_pkg::ENTRY_W),
    .DEPTH (TASK_SLOTS)
  ) u_slot_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  tcts_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign rd_entry = tcts_pkg::slot_entry_t'(ram_rd_data);

  // request side only listens while the sequencer is idle
  assign req_i.ready = (state_q == ST_IDLE);
  assign in_acc      = req_i.valid && req_i.ready;

  // current slot may point past the table after a set current
  assign cur_idx = SLOT_W'(current_q);
  assign cur_ok  = (32'(current_q) < TASK_SLOTS) && valid_q[cur_idx];

  // slot whose ram data arrives this cycle is valid and running
  assign data_ok = valid_q[data_idx_q] && running_q[data_idx_q];

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.result_index = out_q.result_index;
  assign rsp_o.reschedule   = out_q.reschedule;
  assign rsp_o.refilled     = out_q.refilled;
  assign rsp_o.error        = out_q.error;

  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    running_d    = running_q;
    current_d    = current_q;
    nf_d         = nf_q;
    issue_d      = issue_q;
    issue_done_d = issue_done_q;
    live_d       = 1'b0;
    pass_d       = pass_q;
    out_valid_d  = out_valid_q;
    data_idx_d   = issue_q;
    best_d       = best_q;
    sel_d        = sel_q;
    held_d       = held_q;
    res_d        = res_q;
    out_d        = out_q;

    ram_wr_en    = 1'b0;
    ram_wr_addr  = '0;
    ram_wr_data  = '0;
    ram_rd_en    = 1'b0;
    ram_rd_addr  = issue_q;

    alu_req.op   = tcts_pkg::ALU_CMP;
    alu_req.a    = rd_entry.ticks;
    alu_req.b    = best_q;

    // result taken downstream
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_d   = '0;
          state_d = ST_HOLD;
          unique case (tcts_pkg::kind_e'(req_i.kind))
            tcts_pkg::KIND_TICK: begin
              if (cur_ok) begin
                // fetch the current budget, charge it next cycle
                ram_rd_en   = 1'b1;
                ram_rd_addr = cur_idx;
                held_d      = req_i.preempt_held;
                state_d     = ST_TICK;
              end else begin
                res_d.error = tcts_pkg::ERR_NOT_VALID;
              end
            end
            tcts_pkg::KIND_PICK: begin
              issue_d      = '0;
              issue_done_d = 1'b0;
              pass_d       = 1'b0;
              state_d      = ST_SCAN;
            end
            tcts_pkg::KIND_LOAD_MAIN: begin
              ram_wr_en         = 1'b1;
              ram_wr_addr       = '0;
              ram_wr_data.prio  = req_i.priority_req;
              ram_wr_data.ticks = {1'b0, req_i.initial_ticks};
              valid_d[0]        = 1'b1;
              running_d[0]      = req_i.running;
            end
            tcts_pkg::KIND_ENQUEUE: begin
              if (nf_q == NF_FULL) begin
                res_d.error = tcts_pkg::ERR_FULL;
              end else begin
                ram_wr_en         = 1'b1;
                ram_wr_addr       = nf_q[SLOT_W-1:0];
                ram_wr_data.prio  = req_i.priority_req;
                ram_wr_data.ticks = {1'b0, req_i.initial_ticks};
                valid_d[nf_q[SLOT_W-1:0]]   = 1'b1;
                running_d[nf_q[SLOT_W-1:0]] = req_i.running;
                nf_d               = nf_q + 1'b1;
                res_d.result_index = tcts_pkg::IDX_W'(nf_q);
              end
            end
            tcts_pkg::KIND_SET_RUN: begin
              if (32'(req_i.task_index) < TASK_SLOTS) begin
                running_d[SLOT_W'(req_i.task_index)] = req_i.running;
              end
            end
            tcts_pkg::KIND_SET_CUR: begin
              current_d = req_i.task_index;
            end
            default: begin
              // unused kinds answer all zero
            end
          endcase
        end
      end

      ST_TICK: begin
        alu_req.op        = tcts_pkg::ALU_DEC;
        ram_wr_en         = 1'b1;
        ram_wr_addr       = cur_idx;
        ram_wr_data.prio  = rd_entry.prio;
        ram_wr_data.ticks = alu_rsp.value;
        res_d.reschedule  = alu_rsp.flag && !held_q;
        state_d           = ST_HOLD;
      end

      ST_SCAN: begin
        // one slot read per cycle, compare in the next cycle
        ram_rd_en = !issue_done_q;
        live_d    = !issue_done_q;
        if (!issue_done_q) begin
          issue_d = issue_q + 1'b1;
          if (issue_q == LAST_SLOT) begin
            issue_done_d = 1'b1;
          end
        end
        if (live_q) begin
          if (data_idx_q == '0) begin
            // search always starts from slot 0 and its budget
            best_d = rd_entry.ticks;
            sel_d  = '0;
          end else if (data_ok && alu_rsp.flag) begin
            best_d = rd_entry.ticks;
            sel_d  = data_idx_q;
          end
          if (data_idx_q == LAST_SLOT) begin
            if (best_d != '0) begin
              res_d.result_index = tcts_pkg::IDX_W'(sel_d);
              res_d.refilled     = pass_q;
              state_d            = ST_HOLD;
            end else if (!pass_q) begin
              issue_d      = '0;
              issue_done_d = 1'b0;
              live_d       = 1'b0;
              state_d      = ST_REFILL;
            end else begin
              // still nothing to run after one refill
              res_d.result_index = '0;
              res_d.refilled     = 1'b1;
              state_d            = ST_HOLD;
            end
          end
        end
      end

      ST_REFILL: begin
        alu_req.op = tcts_pkg::ALU_REFILL;
        alu_req.b  = {{(tcts_pkg::TICKS_W-tcts_pkg::PRIO_W){1'b0}}, rd_entry.prio};
        ram_rd_en  = !issue_done_q;
        live_d     = !issue_done_q;
        if (!issue_done_q) begin
          issue_d = issue_q + 1'b1;
          if (issue_q == LAST_SLOT) begin
            issue_done_d = 1'b1;
          end
        end
        if (live_q && data_ok) begin
          ram_wr_en         = 1'b1;
          ram_wr_addr       = data_idx_q;
          ram_wr_data.prio  = rd_entry.prio;
          ram_wr_data.ticks = alu_rsp.value;
        end
        if (live_q && (data_idx_q == LAST_SLOT)) begin
          // second search over the refilled budgets
          issue_d      = '0;
          issue_done_d = 1'b0;
          live_d       = 1'b0;
          pass_d       = 1'b1;
          state_d      = ST_SCAN;
        end
      end

      ST_HOLD: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      valid_q      <= '0;
      running_q    <= '0;
      current_q    <= '0;
      nf_q         <= NF_W'(1);
      issue_q      <= '0;
      issue_done_q <= 1'b0;
      live_q       <= 1'b0;
      pass_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      running_q    <= running_d;
      current_q    <= current_d;
      nf_q         <= nf_d;
      issue_q      <= issue_d;
      issue_done_q <= issue_done_d;
      live_q       <= live_d;
      pass_q       <= pass_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    data_idx_q <= data_idx_d;
    best_q     <= best_d;
    sel_q      <= sel_d;
    held_q     <= held_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

endmodule
